>>> hw/rtl/hgqm_pkg.sv
// Shared types and constants for the heightmap greedy quad mesher.
// No dependencies; the mesher rtl and the testbench import this package.
package hgqm_pkg;

  // default tile side in cells
  localparam int unsigned SIDE_DEF = 16;

  // packed stream widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 104;

  // input item kinds carried in tuser
  typedef enum logic [1:0] {
    OP_LOAD_TILE = 2'd0,
    OP_LOAD_EDGE = 2'd1,
    OP_BEGIN     = 2'd2,
    OP_NEXT      = 2'd3
  } opcode_e;

  // scan phases: finished, top faces, then side directions -X, +X, -Y, +Y
  localparam logic [2:0] PH_DONE = 3'd0;
  localparam logic [2:0] PH_TOP  = 3'd1;
  localparam logic [2:0] PH_NX   = 3'd2;
  localparam logic [2:0] PH_PX   = 3'd3;
  localparam logic [2:0] PH_NY   = 3'd4;
  localparam logic [2:0] PH_PY   = 3'd5;

  // face direction codes
  localparam logic [2:0] FACE_TOP = 3'd0;

  // neighbor edge codes
  localparam logic [1:0] EDGE_NX = 2'd0;
  localparam logic [1:0] EDGE_PX = 2'd1;
  localparam logic [1:0] EDGE_NY = 2'd2;
  localparam logic [1:0] EDGE_PY = 2'd3;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_TOP_SCAN,
    S_TOP_H,
    S_TOP_W,
    S_TOP_WCHK,
    S_TOP_D,
    S_TOP_DCHK,
    S_MARK,
    S_SD_SCAN,
    S_PT_H,
    S_PT_HW,
    S_PT_A,
    S_PT_AW,
    S_PT_EVAL,
    S_PHASE,
    S_EMIT
  } state_e;

endpackage

>>> hw/rtl/heightmap_greedy_quad_mesher.sv
// Heightmap greedy quad mesher: loads, begin and next-quad items under one sequencer.
// Each load is written when accepted; a begin runs a used-map clearing pass over all SIDE*SIDE
// cells (256 at the default side) with the input held off. A next item walks tile probes, side
// probes and the marking of each covered cell; a done marker is sent through S_EMIT like a quad.
// One item at a time; a finished quad waits in the output register. rst_ni clears sequencer,
// scan position, origin and neighbor mask; the RAM stores are undefined until written.
module heightmap_greedy_quad_mesher
  import hgqm_pkg::*;
#(
  parameter int unsigned SIDE = SIDE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // position[7:0], edge_side[9:8], height_value[25:10], tile_x[53:26],
  // tile_y[81:54], neighbor_mask[85:82], zero fill[87:86]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // quad_x[31:0], quad_y[63:32], quad_z[79:64], face_dir[82:80],
  // quad width or run length[87:83], depth or height difference[103:88]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // done_res[0]
  output logic                   m_axis_tuser
);

  localparam int unsigned NCELL = SIDE * SIDE;
  localparam int unsigned NEDGE = 4 * SIDE;
  localparam int unsigned CELLW = $clog2(NCELL);
  localparam int unsigned EDGW  = $clog2(NEDGE);
  localparam int unsigned IDXW  = $clog2(SIDE + 1);
  localparam int unsigned SUMW  = IDXW + 1;

  // input fields
  logic [7:0]  in_pos;
  logic [1:0]  in_side;
  logic [15:0] in_hv;
  logic [27:0] in_tx, in_ty;
  logic [3:0]  in_mask;
  logic        in_acc;

  assign in_pos  = s_axis_tdata[7:0];
  assign in_side = s_axis_tdata[9:8];
  assign in_hv   = s_axis_tdata[25:10];
  assign in_tx   = s_axis_tdata[53:26];
  assign in_ty   = s_axis_tdata[81:54];
  assign in_mask = s_axis_tdata[85:82];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // state
  state_e           state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  logic [IDXW-1:0]  row_q, row_d, col_q, col_d;
  logic [IDXW-1:0]  w_q, w_d, d_q, d_d, i_q, i_d, j_q, j_d, s_q, s_d;
  logic [IDXW-1:0]  pr_q, pr_d, pc_q, pc_d;
  logic [15:0]      h_q, h_d, a_q, a_d, ph_q, ph_d, pa_q, pa_d;
  logic             first_q, first_d, nbe_q, nbe_d;
  logic [3:0]       present_q, present_d;
  logic [27:0]      ox_q, ox_d, oy_q, oy_d;
  logic [CELLW-1:0] clr_q, clr_d;
  logic             mv_q, mv_d;
  logic             mu_q, mu_d;
  logic [OUT_TDATA_W-1:0] md_q, md_d;

  // ram ports
  logic             tile_we, edge_we;
  logic [CELLW-1:0] tile_raddr;
  logic [EDGW-1:0]  edge_raddr, edge_waddr;
  logic [15:0]      tile_rd, edge_rd;
  logic [31:0]      edge_wsum;
  logic             used_we, used_wdata, used_rd;
  logic [CELLW-1:0] used_waddr;

  assign tile_we    = in_acc && (s_axis_tuser == OP_LOAD_TILE) && (32'(in_pos) < 32'(NCELL));
  assign edge_we    = in_acc && (s_axis_tuser == OP_LOAD_EDGE) && (32'(in_pos) < 32'(SIDE));
  assign edge_wsum  = 32'(in_side) * 32'(SIDE) + 32'(in_pos);
  assign edge_waddr = edge_wsum[EDGW-1:0];

  hgqm_ram #(.WIDTH(16), .DEPTH(NCELL)) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (CELLW'(in_pos)),
    .wdata_i (in_hv),
    .raddr_i (tile_raddr),
    .rdata_o (tile_rd)
  );

  hgqm_ram #(.WIDTH(16), .DEPTH(NEDGE)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (in_hv),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  // cell cursor for the current probe
  logic [SUMW-1:0]  cur_r, cur_c;
  logic [31:0]      cur_lin;
  logic [CELLW-1:0] cell_idx;

  always_comb begin
    case (state_q)
      S_TOP_SCAN: begin
        cur_r = SUMW'(row_q);
        cur_c = SUMW'(col_q);
      end
      S_TOP_W: begin
        cur_r = SUMW'(row_q);
        cur_c = SUMW'(col_q) + SUMW'(w_q);
      end
      S_TOP_D: begin
        cur_r = SUMW'(row_q) + SUMW'(d_q);
        cur_c = SUMW'(col_q) + SUMW'(j_q);
      end
      S_MARK: begin
        cur_r = SUMW'(row_q) + SUMW'(i_q);
        cur_c = SUMW'(col_q) + SUMW'(j_q);
      end
      default: begin
        cur_r = SUMW'(pr_q);
        cur_c = SUMW'(pc_q);
      end
    endcase
  end

  assign cur_lin  = 32'(cur_r) * 32'(SIDE) + 32'(cur_c);
  assign cell_idx = cur_lin[CELLW-1:0];

  // used-cell map: cleared after begin, set while marking, read beside the tile probe
  assign used_we    = (state_q == S_CLEAR) || (state_q == S_MARK);
  assign used_waddr = (state_q == S_CLEAR) ? clr_q : cell_idx;
  assign used_wdata = (state_q == S_MARK);

  hgqm_ram #(.WIDTH(1), .DEPTH(NCELL)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (cell_idx),
    .rdata_o (used_rd)
  );

  // neighbor of the side probe point
  logic            along_rows;
  logic            nb_edge;
  logic [1:0]      nb_side;
  logic [IDXW-1:0] nb_off, nb_r, nb_c;
  logic [31:0]     nb_lin, nb_elin;

  assign along_rows = (phase_q == PH_NX) || (phase_q == PH_PX);

  always_comb begin
    nb_r = pr_q;
    nb_c = pc_q;
    case (phase_q)
      PH_NX: begin
        nb_edge = (pc_q == '0);
        nb_side = EDGE_NX;
        nb_off  = pr_q;
        nb_c    = pc_q - IDXW'(1);
      end
      PH_PX: begin
        nb_edge = (32'(pc_q) == 32'(SIDE - 1));
        nb_side = EDGE_PX;
        nb_off  = pr_q;
        nb_c    = pc_q + IDXW'(1);
      end
      PH_NY: begin
        nb_edge = (pr_q == '0);
        nb_side = EDGE_NY;
        nb_off  = pc_q;
        nb_r    = pr_q - IDXW'(1);
      end
      default: begin
        nb_edge = (32'(pr_q) == 32'(SIDE - 1));
        nb_side = EDGE_PY;
        nb_off  = pc_q;
        nb_r    = pr_q + IDXW'(1);
      end
    endcase
  end

  assign nb_lin     = 32'(nb_r) * 32'(SIDE) + 32'(nb_c);
  assign nb_elin    = 32'(nb_side) * 32'(SIDE) + 32'(nb_off);
  assign edge_raddr = nb_elin[EDGW-1:0];
  assign tile_raddr = (state_q == S_PT_A) ? nb_lin[CELLW-1:0] : cell_idx;

  // decisions shared by next state and datapath
  logic            out_free;
  logic            ts_end, ts_wrap, tw_go, tw_match, td_end, td_rowdone, td_fail, mk_last;
  logic            th_skip, clr_last;
  logic [IDXW-1:0] inner, outer, snext;
  logic [SUMW-1:0] inner_snext;
  logic            sd_end, sd_wrap, ev_cont, ev_more, nb_skip;
  logic [2:0]      phase_nx;

  assign out_free    = !mv_q || m_axis_tready;
  assign clr_last    = 32'(clr_q) == 32'(NCELL - 1);
  assign ts_end      = 32'(row_q) >= 32'(SIDE);
  assign ts_wrap     = 32'(col_q) >= 32'(SIDE);
  assign th_skip     = used_rd || (tile_rd == '0);
  assign tw_go       = 32'(cur_c) < 32'(SIDE);
  assign tw_match    = !used_rd && (tile_rd == h_q);
  assign td_end      = 32'(cur_r) >= 32'(SIDE);
  assign td_rowdone  = (j_q == w_q);
  assign td_fail     = used_rd || (tile_rd != h_q);
  assign mk_last     = (i_q + IDXW'(1) >= d_q) && (j_q + IDXW'(1) >= w_q);
  assign inner       = along_rows ? row_q : col_q;
  assign outer       = along_rows ? col_q : row_q;
  assign sd_end      = 32'(outer) >= 32'(SIDE);
  assign sd_wrap     = 32'(inner) >= 32'(SIDE);
  assign snext       = first_q ? IDXW'(1) : s_q + IDXW'(1);
  assign inner_snext = SUMW'(inner) + SUMW'(snext);
  assign ev_cont     = first_q ? (ph_q > pa_q) : ((ph_q == h_q) && (pa_q == a_q));
  assign ev_more     = 32'(inner_snext) < 32'(SIDE);
  assign nb_skip     = nb_edge && !present_q[nb_side];
  assign phase_nx    = (phase_q == PH_PY) ? PH_DONE : phase_q + 3'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == OP_BEGIN)) begin
          state_d = S_CLEAR;
        end else if (in_acc && (s_axis_tuser == OP_NEXT)) begin
          if (phase_q == PH_DONE) begin
            state_d = S_EMIT;
          end else if (phase_q == PH_TOP) begin
            state_d = S_TOP_SCAN;
          end else begin
            state_d = S_SD_SCAN;
          end
        end
      end
      S_CLEAR: state_d = clr_last ? S_IDLE : S_CLEAR;
      S_TOP_SCAN: begin
        if (ts_end) begin
          state_d = S_PHASE;
        end else if (!ts_wrap) begin
          state_d = S_TOP_H;
        end
      end
      S_TOP_H:    state_d = th_skip ? S_TOP_SCAN : S_TOP_W;
      S_TOP_W:    state_d = tw_go ? S_TOP_WCHK : S_TOP_D;
      S_TOP_WCHK: state_d = tw_match ? S_TOP_W : S_TOP_D;
      S_TOP_D: begin
        if (td_end) begin
          state_d = S_MARK;
        end else if (!td_rowdone) begin
          state_d = S_TOP_DCHK;
        end
      end
      S_TOP_DCHK: state_d = td_fail ? S_MARK : S_TOP_D;
      S_MARK:     state_d = mk_last ? S_EMIT : S_MARK;
      S_SD_SCAN: begin
        if (sd_end) begin
          state_d = S_PHASE;
        end else if (!sd_wrap) begin
          state_d = S_PT_H;
        end
      end
      S_PT_H:  state_d = S_PT_HW;
      S_PT_HW: state_d = S_PT_A;
      S_PT_A:  state_d = nb_skip ? S_PT_EVAL : S_PT_AW;
      S_PT_AW: state_d = S_PT_EVAL;
      S_PT_EVAL: begin
        if (first_q && !ev_cont) begin
          state_d = S_SD_SCAN;
        end else if (ev_cont && ev_more) begin
          state_d = S_PT_H;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_PHASE: state_d = (phase_nx == PH_DONE) ? S_EMIT : S_SD_SCAN;
      S_EMIT:  state_d = out_free ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  // world coordinates of the scan start cell
  logic [31:0] qx, qy;
  assign qx = 32'({{4{ox_q[27]}}, ox_q} * 32'(SIDE)) + 32'(col_q);
  assign qy = 32'({{4{oy_q[27]}}, oy_q} * 32'(SIDE)) + 32'(row_q);

  // datapath and output register
  always_comb begin
    phase_d   = phase_q;
    row_d     = row_q;
    col_d     = col_q;
    w_d       = w_q;
    d_d       = d_q;
    i_d       = i_q;
    j_d       = j_q;
    s_d       = s_q;
    pr_d      = pr_q;
    pc_d      = pc_q;
    h_d       = h_q;
    a_d       = a_q;
    ph_d      = ph_q;
    pa_d      = pa_q;
    first_d   = first_q;
    nbe_d     = nbe_q;
    present_d = present_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    clr_d     = clr_q;
    mv_d      = mv_q && !m_axis_tready;
    mu_d      = mu_q;
    md_d      = md_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == OP_BEGIN)) begin
          ox_d      = in_tx;
          oy_d      = in_ty;
          present_d = in_mask;
          clr_d     = '0;
          phase_d   = PH_TOP;
          row_d     = '0;
          col_d     = '0;
        end
      end
      S_CLEAR: clr_d = clr_q + CELLW'(1);
      S_TOP_SCAN: begin
        if (!ts_end && ts_wrap) begin
          row_d = row_q + IDXW'(1);
          col_d = '0;
        end
      end
      S_TOP_H: begin
        if (th_skip) begin
          col_d = col_q + IDXW'(1);
        end else begin
          h_d = tile_rd;
          w_d = IDXW'(1);
        end
      end
      S_TOP_W: begin
        if (!tw_go) begin
          d_d = IDXW'(1);
          j_d = '0;
        end
      end
      S_TOP_WCHK: begin
        if (tw_match) begin
          w_d = w_q + IDXW'(1);
        end else begin
          d_d = IDXW'(1);
          j_d = '0;
        end
      end
      S_TOP_D: begin
        if (td_end) begin
          i_d = '0;
          j_d = '0;
        end else if (td_rowdone) begin
          d_d = d_q + IDXW'(1);
          j_d = '0;
        end
      end
      S_TOP_DCHK: begin
        if (td_fail) begin
          i_d = '0;
          j_d = '0;
        end else begin
          j_d = j_q + IDXW'(1);
        end
      end
      S_MARK: begin
        if (j_q + IDXW'(1) < w_q) begin
          j_d = j_q + IDXW'(1);
        end else begin
          j_d = '0;
          i_d = i_q + IDXW'(1);
        end
      end
      S_SD_SCAN: begin
        if (!sd_end) begin
          if (sd_wrap) begin
            if (along_rows) begin
              col_d = col_q + IDXW'(1);
              row_d = '0;
            end else begin
              row_d = row_q + IDXW'(1);
              col_d = '0;
            end
          end else begin
            pr_d    = row_q;
            pc_d    = col_q;
            first_d = 1'b1;
          end
        end
      end
      S_PT_HW: ph_d = tile_rd;
      S_PT_A: begin
        nbe_d = nb_edge;
        if (nb_skip) begin
          pa_d = '0;
        end
      end
      S_PT_AW: pa_d = nbe_q ? edge_rd : tile_rd;
      S_PT_EVAL: begin
        if (first_q) begin
          h_d = ph_q;
          a_d = pa_q;
        end
        if (first_q && !ev_cont) begin
          if (along_rows) begin
            row_d = row_q + IDXW'(1);
          end else begin
            col_d = col_q + IDXW'(1);
          end
        end else if (ev_cont) begin
          s_d     = snext;
          first_d = 1'b0;
          if (along_rows) begin
            pr_d = inner_snext[IDXW-1:0];
            pc_d = col_q;
          end else begin
            pr_d = row_q;
            pc_d = inner_snext[IDXW-1:0];
          end
        end
      end
      S_PHASE: begin
        phase_d = phase_nx;
        row_d   = '0;
        col_d   = '0;
      end
      S_EMIT: begin
        if (out_free) begin
          mv_d = 1'b1;
          if (phase_q == PH_DONE) begin
            mu_d = 1'b1;
            md_d = '0;
          end else if (phase_q == PH_TOP) begin
            mu_d = 1'b0;
            md_d = {16'(d_q), 5'(w_q), FACE_TOP, 16'(h_q - 16'd1), qy, qx};
            col_d = col_q + w_q;
          end else begin
            mu_d = 1'b0;
            md_d = {16'(h_q - a_q), 5'(s_q), 3'(phase_q - 3'd1), a_q, qy, qx};
            if (along_rows) begin
              row_d = row_q + s_q;
            end else begin
              col_d = col_q + s_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_DONE;
      row_q     <= '0;
      col_q     <= '0;
      present_q <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      mv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      row_q     <= row_d;
      col_q     <= col_d;
      present_q <= present_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      mv_q      <= mv_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    d_q     <= d_d;
    i_q     <= i_d;
    j_q     <= j_d;
    s_q     <= s_d;
    pr_q    <= pr_d;
    pc_q    <= pc_d;
    h_q     <= h_d;
    a_q     <= a_d;
    ph_q    <= ph_d;
    pa_q    <= pa_d;
    first_q <= first_d;
    nbe_q   <= nbe_d;
    clr_q   <= clr_d;
    mu_q    <= mu_d;
    md_q    <= md_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = mu_q;

  // a stalled output transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && !m_axis_tready) |=> (mv_q && $stable(md_q) && $stable(mu_q)))
    else $error("output transaction changed while stalled");

  // the done marker carries all-zero quad fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && mu_q) |-> (md_q == '0))
    else $error("done marker with nonzero quad fields");

  // every quad has a nonzero depth or height difference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && !mu_q) |-> (md_q[103:88] != 16'd0))
    else $error("quad with zero v extent");

endmodule

>>> hw/rtl/hgqm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the tile height, neighbor edge and used-cell stores; no dependencies.
module hgqm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> dv/tb_heightmap_greedy_quad_mesher.sv
// Self-checking testbench for the heightmap greedy quad mesher stream block.
// Drives load, begin and next transactions from a queue, predicts every quad in
// the testbench and checks each output transaction. Depends on hgqm_pkg and the rtl.
`timescale 1ns / 100ps

module tb_heightmap_greedy_quad_mesher;
  import hgqm_pkg::*;

  localparam int unsigned N = SIDE_DEF;
  localparam int unsigned STALL_LIMIT = 60000;

  typedef struct {
    opcode_e     op;
    logic [7:0]  pos;
    logic [1:0]  side;
    logic [15:0] hgt;
    logic [27:0] tx;
    logic [27:0] ty;
    logic [3:0]  mask;
  } mesh_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] z;
    logic [2:0]  dir;
    logic [4:0]  u;
    logic [15:0] v;
  } quad_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  heightmap_greedy_quad_mesher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mirror of the block state
  logic [15:0] tile_h [N*N];
  logic [15:0] edge_h [4*N];
  bit          used_map [N*N];
  logic [3:0]  present;
  logic [31:0] org_x;
  logic [31:0] org_y;
  logic [2:0]  phase;
  int          row;
  int          col;

  mesh_cmd_t pending_q [$];
  quad_t     quad_q [$];
  int        errors = 0;
  int        sent = 0;
  int        taken = 0;
  int        quads_seen = 0;
  int        dones_seen = 0;
  bit        saw_done = 0;
  bit        in_fired = 0;
  bit        out_fired = 0;

  function automatic logic [15:0] cell_h(int r, int c);
    return tile_h[r*N+c];
  endfunction

  function automatic logic [15:0] edge_or_zero(int s, int off);
    return present[s] ? edge_h[s*N+off] : 16'd0;
  endfunction

  // height of the column next to (r, c) in face direction d
  function automatic logic [15:0] beside(int d, int r, int c);
    case (d)
      1: return c == 0 ? edge_or_zero(EDGE_NX, r) : cell_h(r, c-1);
      2: return c == N-1 ? edge_or_zero(EDGE_PX, r) : cell_h(r, c+1);
      3: return r == 0 ? edge_or_zero(EDGE_NY, c) : cell_h(r-1, c);
      default: return r == N-1 ? edge_or_zero(EDGE_PY, c) : cell_h(r+1, c);
    endcase
  endfunction

  function automatic quad_t make_quad(int r, int c, logic [15:0] z, int d, int u, int v);
    quad_t q;
    q.done = 1'b0;
    q.x    = org_x * 32'(N) + 32'(c);
    q.y    = org_y * 32'(N) + 32'(r);
    q.z    = z;
    q.dir  = 3'(d);
    q.u    = 5'(u);
    q.v    = 16'(v);
    return q;
  endfunction

  // greedy top rectangle search from the current scan position
  task automatic top_quad(output bit got, output quad_t q);
    logic [15:0] h;
    int r, c, w, d;
    bit ok;
    got = 0;
    while (row < N && !got) begin
      if (col >= N) begin
        row++;
        col = 0;
      end else begin
        r = row;
        c = col;
        h = cell_h(r, c);
        if (h == 0 || used_map[r*N+c]) begin
          col++;
        end else begin
          w = 1;
          while (c + w < N && !used_map[r*N+c+w] && cell_h(r, c+w) == h) w++;
          d = 1;
          ok = 1;
          while (r + d < N && ok) begin
            for (int j = 0; j < w; j++)
              if (used_map[(r+d)*N+c+j] || cell_h(r+d, c+j) != h) ok = 0;
            if (ok) d++;
          end
          for (int i = 0; i < d; i++)
            for (int j = 0; j < w; j++) used_map[(r+i)*N+c+j] = 1;
          q = make_quad(r, c, h - 16'd1, FACE_TOP, w, d);
          col = c + w;
          got = 1;
        end
      end
    end
  endtask

  // side runs; directions 1 and 2 advance along the row index
  task automatic side_run(input int d, output bit got, output quad_t q);
    bit along;
    int o, i, r, c, s, rr, cc;
    logic [15:0] h, a;
    bit stop;
    along = d <= 2;
    o = along ? col : row;
    i = along ? row : col;
    got = 0;
    while (o < N && !got) begin
      if (i >= N) begin
        o++;
        i = 0;
      end else begin
        r = along ? i : o;
        c = along ? o : i;
        h = cell_h(r, c);
        a = beside(d, r, c);
        if (h <= a) begin
          i++;
        end else begin
          s = 1;
          stop = 0;
          while (i + s < N && !stop) begin
            rr = along ? r + s : r;
            cc = along ? c : c + s;
            if (cell_h(rr, cc) != h || beside(d, rr, cc) != a) stop = 1;
            else s++;
          end
          q = make_quad(r, c, a, d, s, h - a);
          i += s;
          got = 1;
        end
      end
    end
    if (along) begin
      col = o;
      row = i;
    end else begin
      row = o;
      col = i;
    end
  endtask

  // apply one accepted command to the mirror, queue the quad it yields
  task automatic mesh_apply(input mesh_cmd_t cmd);
    quad_t q;
    bit got;
    got = 0;
    case (cmd.op)
      OP_LOAD_TILE: tile_h[cmd.pos] = cmd.hgt;
      OP_LOAD_EDGE: if (cmd.pos < N) edge_h[cmd.side*N+cmd.pos] = cmd.hgt;
      OP_BEGIN: begin
        org_x   = {{4{cmd.tx[27]}}, cmd.tx};
        org_y   = {{4{cmd.ty[27]}}, cmd.ty};
        present = cmd.mask;
        foreach (used_map[k]) used_map[k] = 0;
        phase = PH_TOP;
        row   = 0;
        col   = 0;
      end
      default: begin
        while (phase >= PH_TOP && phase <= PH_PY && !got) begin
          if (phase == PH_TOP) top_quad(got, q);
          else side_run(phase - 1, got, q);
          if (!got) begin
            phase = phase == PH_PY ? PH_DONE : phase + 3'd1;
            row   = 0;
            col   = 0;
          end
        end
        if (!got) begin
          phase = PH_DONE;
          q = '{done: 1'b1, x: '0, y: '0, z: '0, dir: '0, u: '0, v: '0};
        end
        quad_q.insert(quad_q.size(), q);
      end
    endcase
  endtask

  // input driver: holds each transaction until accepted, then idles for a random gap unless in a burst
  int  in_gap = 0;
  bit  in_burst = 0;
  mesh_cmd_t cur;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_NEXT;
      in_gap        = 0;
    end else if (!(s_axis_tvalid && !in_fired)) begin
      in_fired = 0;
      if (in_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        s_axis_tdata  <= {2'b00, cur.mask, cur.ty, cur.tx, cur.hgt, cur.side, cur.pos};
        s_axis_tuser  <= cur.op;
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 79) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 5);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output sink: random wait per result, one long hold-off to back up the input
  int  out_gap = 0;
  bit  long_hold_done = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_gap = 2;
    end else begin
      if (out_fired) begin
        out_fired = 0;
        if (!long_hold_done && quads_seen >= 40) begin
          long_hold_done = 1;
          out_gap = 400;
        end else begin
          out_gap = in_burst ? 0 : $urandom_range(0, 5);
        end
      end
      if (out_gap > 0) begin
        m_axis_tready <= 1'b0;
        out_gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // checker and predictor at the rising edge, plus the stall watchdog
  int    idle_cycles = 0;
  quad_t exp_q;
  quad_t got_q;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        out_fired = 1;
        got_q = '{done: m_axis_tuser, x: m_axis_tdata[31:0], y: m_axis_tdata[63:32],
                  z: m_axis_tdata[79:64], dir: m_axis_tdata[82:80],
                  u: m_axis_tdata[87:83], v: m_axis_tdata[103:88]};
        if (got_q.done) begin
          saw_done = 1;
          dones_seen++;
        end else begin
          quads_seen++;
        end
        if (quad_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result done=%0d x=%0d y=%0d z=%0d dir=%0d u=%0d v=%0d",
                   $realtime, got_q.done, $signed(got_q.x), $signed(got_q.y), got_q.z,
                   got_q.dir, got_q.u, got_q.v);
        end else begin
          exp_q = quad_q.pop_front();
          if (exp_q !== got_q) begin
            errors++;
            $display("%0t: mismatch expected done=%0d x=%0d y=%0d z=%0d dir=%0d u=%0d v=%0d",
                     $realtime, exp_q.done, $signed(exp_q.x), $signed(exp_q.y), exp_q.z,
                     exp_q.dir, exp_q.u, exp_q.v);
            $display("%0t:          actual   done=%0d x=%0d y=%0d z=%0d dir=%0d u=%0d v=%0d",
                     $realtime, got_q.done, $signed(got_q.x), $signed(got_q.y), got_q.z,
                     got_q.dir, got_q.u, got_q.v);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        in_fired = 1;
        taken++;
        mesh_apply('{op: opcode_e'(s_axis_tuser), pos: s_axis_tdata[7:0],
                     side: s_axis_tdata[9:8], hgt: s_axis_tdata[25:10],
                     tx: s_axis_tdata[53:26], ty: s_axis_tdata[81:54],
                     mask: s_axis_tdata[85:82]});
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send(input opcode_e op, input int pos, input int side, input int hgt,
                      input logic [27:0] tx = '0, input logic [27:0] ty = '0,
                      input logic [3:0] mask = '0);
    mesh_cmd_t cmd;
    cmd.op   = op;
    cmd.pos  = 8'(pos);
    cmd.side = 2'(side);
    cmd.hgt  = 16'(hgt);
    cmd.tx   = tx;
    cmd.ty   = ty;
    cmd.mask = mask;
    pending_q.insert(pending_q.size(), cmd);
    sent++;
  endtask

  task automatic wait_idle();
    while (taken != sent || quad_q.size() != 0) @(posedge clk_i);
  endtask

  // issue next transactions in chunks until the done marker shows up
  task automatic drain_build(input int max_chunks);
    int chunks;
    chunks = 0;
    saw_done = 0;
    while (!saw_done && chunks < max_chunks) begin
      repeat (8) send(OP_NEXT, $urandom, $urandom, $urandom, 28'($urandom), 28'($urandom),
                      4'($urandom));
      chunks++;
      wait_idle();
    end
  endtask

  function automatic int rand_height();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return 0;
    if (k < 6) return 1;
    if (k < 8) return 2;
    if (k == 8) return $urandom_range(0, 65535);
    return 65535;
  endfunction

  int builds = 0;
  int r0, c0, rh, rw, hv;
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_NEXT;
    m_axis_tready = 1'b0;
    present = '0;
    org_x   = '0;
    org_y   = '0;
    phase   = PH_DONE;
    row     = 0;
    col     = 0;
    foreach (used_map[k]) used_map[k] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // next before any begin returns the done marker
    send(OP_NEXT, 0, 0, 0);
    send(OP_NEXT, 255, 3, 65535, 28'hFFFFFFF, 28'hFFFFFFF, 4'hF);
    wait_idle();

    // full tile at the maximum height, every edge written
    for (int p = 0; p < N*N; p++) send(OP_LOAD_TILE, p, $urandom, 65535);
    for (int s = 0; s < 4; s++)
      for (int p = 0; p < N; p++) send(OP_LOAD_EDGE, p, s, s == 0 ? 0 : $urandom_range(0, 65535));
    // edge load past the end of the line is dropped
    send(OP_LOAD_EDGE, 16, EDGE_PX, 7);
    send(OP_LOAD_EDGE, 255, EDGE_NY, 9);
    wait_idle();

    // whole-tile quad at full width, no neighbors, largest x and smallest y origin
    send(OP_BEGIN, 0, 0, 0, 28'h7FFFFFF, 28'h8000000, 4'h0);
    drain_build(40);
    send(OP_NEXT, 0, 0, 0);

    // all neighbors present, smallest x and largest y origin; a load and a restart mid-scan
    send(OP_BEGIN, 0, 0, 0, 28'h8000000, 28'h7FFFFFF, 4'hF);
    send(OP_NEXT, 0, 0, 0);
    send(OP_LOAD_TILE, 17, 0, 0);
    send(OP_NEXT, 0, 0, 0);
    send(OP_LOAD_TILE, 0, 0, 1);
    send(OP_BEGIN, 0, 0, 0, 28'h0000000, 28'hFFFFFFF, 4'b0101);
    drain_build(80);

    // random builds: edits, then a begin and a run of nexts
    while (sent < 950) begin
      if ($urandom_range(0, 2) == 0) begin
        hv = rand_height();
        rh = $urandom_range(1, 8);
        rw = $urandom_range(1, 8);
        r0 = $urandom_range(0, N - rh);
        c0 = $urandom_range(0, N - rw);
        for (int i = 0; i < rh; i++)
          for (int j = 0; j < rw; j++) send(OP_LOAD_TILE, (r0+i)*N + c0 + j, $urandom, hv);
      end
      repeat ($urandom_range(4, 20)) send(OP_LOAD_TILE, $urandom_range(0, 255), $urandom,
                                          rand_height());
      repeat ($urandom_range(0, 6)) send(OP_LOAD_EDGE, $urandom_range(0, 31), $urandom,
                                         rand_height());
      send(OP_BEGIN, $urandom, $urandom, $urandom, 28'($urandom), 28'($urandom),
           4'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        drain_build($urandom_range(1, 3));
        send(OP_LOAD_TILE, $urandom_range(0, 255), 0, rand_height());
        send(OP_BEGIN, $urandom, $urandom, $urandom, 28'($urandom), 28'($urandom),
             4'($urandom));
      end
      drain_build(200);
      builds++;
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("Ran %0d input transactions over %0d random builds: %0d quads, %0d done markers.",
             taken, builds, quads_seen, dones_seen);
    if (errors == 0 && quad_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
